// ----- src/disk_head_scan_scheduler_core_macros.svh -----
// Assertion macros shared by the disk head scan scheduler checkers.
`ifndef DISK_HEAD_SCAN_SCHEDULER_CORE_MACROS_SVH
`define DISK_HEAD_SCAN_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DHS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("disk head scan scheduler: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DHS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("disk head scan scheduler: check failed");

`endif

// ----- src/dhs_pkg.sv -----
// Package: types, constants and the sort key of the disk head scan scheduler.
`default_nettype none
package dhs_pkg;
	localparam int MAX_REQ_DEF = 16;
	localparam int POS_W       = 16;
	localparam int TOTAL_W     = 24;
	localparam int KEY_W       = POS_W + 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [TOTAL_W-1:0] SEEK_MAX = {TOTAL_W{1'b1}};

	// scheduling modes
	localparam logic [1:0] MODE_FCFS  = 2'd0;
	localparam logic [1:0] MODE_SCAN  = 2'd1;
	localparam logic [1:0] MODE_CSCAN = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	// sweep endpoint progress
	typedef enum logic [1:0] {
		EP_END,
		EP_ZERO,
		EP_DONE
	} ep_t;

	typedef struct packed {
		logic pop;
		logic sort_en;
		logic parity;
	} cell_ctrl_t;

	typedef struct packed {
		logic             cscan;
		logic [POS_W-1:0] head;
	} key_cfg_t;

	// {empty, lower group, value or inverted value}: ascending key order is service order
	function automatic logic [KEY_W-1:0] make_key(input logic vld, input logic [POS_W-1:0] val,
			input key_cfg_t kcfg);
		logic up;
		logic [POS_W-1:0] low;
		up  = val > kcfg.head;
		low = (!up && !kcfg.cscan) ? ~val : val;
		return {~vld, ~up, low};
	endfunction
endpackage
`default_nettype wire

// ----- src/dhs_cell.sv -----
// One cell of the request chain: holds a cylinder, loads, shifts and swaps with neighbors.
`default_nettype none
module dhs_cell #(
	parameter bit CELL_ODD = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dhs_pkg::cell_ctrl_t         ctrl,
	input  dhs_pkg::key_cfg_t           kcfg,
	input  logic                        load_en,
	input  logic [dhs_pkg::POS_W-1:0]   load_val,
	input  logic [dhs_pkg::KEY_W-1:0]   left_key,
	input  logic [dhs_pkg::POS_W-1:0]   left_val,
	input  logic                        left_vld,
	input  logic [dhs_pkg::KEY_W-1:0]   right_key,
	input  logic [dhs_pkg::POS_W-1:0]   right_val,
	input  logic                        right_vld,
	output logic [dhs_pkg::KEY_W-1:0]   key,
	output logic [dhs_pkg::POS_W-1:0]   val,
	output logic                        vld
);
	import dhs_pkg::*;

	logic [POS_W-1:0] val_q;
	logic             vld_q;
	logic             lower;
	logic             swap_r;
	logic             swap_l;

	assign key    = make_key(vld_q, val_q, kcfg);
	assign val    = val_q;
	assign vld    = vld_q;
	// odd-even transposition: this cell is the low side of its pair when parity matches
	assign lower  = (CELL_ODD == ctrl.parity);
	assign swap_r = lower && (key > right_key);
	assign swap_l = !lower && (left_key > key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load_en) begin
			vld_q <= 1'b1;
		end else if (ctrl.pop) begin
			vld_q <= right_vld;
		end else if (ctrl.sort_en) begin
			if (swap_r) begin
				vld_q <= right_vld;
			end else if (swap_l) begin
				vld_q <= left_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			val_q <= load_val;
		end else if (ctrl.pop) begin
			val_q <= right_val;
		end else if (ctrl.sort_en) begin
			if (swap_r) begin
				val_q <= right_val;
			end else if (swap_l) begin
				val_q <= left_val;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/disk_head_scan_scheduler_core.sv -----
// Disk head scan scheduler: FCFS, SCAN and C-SCAN over a chain of request cells.
//
// Usage notes:
// - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; write it
//   only between batches. Index 0 mode, 1 end cylinder, 2 start head; others ignored.
// - Slave stream: one request cylinder per transfer, one per cycle while s_tready is high.
//   s_tlast closes the batch. Requests past MAX_REQUESTS are dropped, and every move of
//   that batch carries the dropped flag in m_tuser.
// - After the last request, SCAN and C-SCAN run an odd-even transposition sort across
//   the cells; FCFS skips it. Moves then leave at one per cycle while m_tready allows,
//   through the output register; a move to a request pops it off cell 0, the end and
//   wrap moves pop nothing.
// - Master stream: one move per transfer; m_tlast marks the final move of the schedule.
//   A stall on m_tready holds the move and freezes the chain; s_tready stays low until
//   the final move has been registered.
// - Reset (arst_n low) empties the chain, clears the fill count and drop flag, drops any
//   pending move and restores the register defaults (FCFS, end 65535, head 0).
`default_nettype none
module disk_head_scan_scheduler_core #(
	parameter int MAX_REQUESTS = dhs_pkg::MAX_REQ_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dhs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dhs_pkg::POS_W-1:0]       cfg_data,
	// requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [15:0] request_cylinder
	input  logic                            s_tlast,   // last_request
	// moves
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [71:0]                     m_tdata,   // [15:0] from_position,
	                                                   // [31:16] to_position,
	                                                   // [47:32] move_distance,
	                                                   // [71:48] seek_total
	output logic                            m_tuser,   // dropped_flag
	output logic                            m_tlast    // final_move
);
	import dhs_pkg::*;

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int SW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	// config registers
	logic [1:0]       mode_q;
	logic [POS_W-1:0] end_q;
	logic [POS_W-1:0] head_q;

	// batch control
	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    rem_q;
	logic             ovf_q;
	logic [SW-1:0]    sort_cnt_q;
	ep_t              ep_q, ep_d;
	logic [POS_W-1:0] prev_q;
	logic [TOTAL_W-1:0] total_q;

	// output register
	logic               m_tvalid_q;
	logic [POS_W-1:0]   from_q;
	logic [POS_W-1:0]   to_q;
	logic [POS_W-1:0]   dist_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               drop_q;
	logic               fin_q;

	logic in_xfer;
	logic full;
	logic sweep;
	logic cscan;
	logic sort_en;
	logic emit_ok;
	logic emit_go;

	// chain wiring
	logic [KEY_W-1:0] key_c [MAX_REQUESTS];
	logic [POS_W-1:0] val_c [MAX_REQUESTS];
	logic             vld_c [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0] load_en;
	cell_ctrl_t       ctrl;
	key_cfg_t         kcfg;

	// next move
	logic [POS_W-1:0]   to_pos;
	logic               pop;
	logic               fin;
	logic               front_up;
	logic [POS_W-1:0]   move_dist;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_n;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign full      = (cnt_q == CW'(MAX_REQUESTS));
	assign sweep     = (mode_q == MODE_SCAN) || (mode_q == MODE_CSCAN);
	assign cscan     = (mode_q == MODE_CSCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FCFS;
			end_q  <= {POS_W{1'b1}};
			head_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_END:  end_q  <= cfg_data;
				REG_HEAD: head_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (in_xfer && s_tlast) state_d = sweep ? ST_SORT : ST_EMIT;
			ST_SORT: if (sort_cnt_q == SW'(MAX_REQUESTS - 1)) state_d = ST_EMIT;
			ST_EMIT: if (emit_go && fin) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_LOAD);
		sort_en  = (state_q == ST_SORT);
		emit_ok  = (state_q == ST_EMIT);
	end

	// in the emit state, a new move is made whenever the output register is free or draining
	assign emit_go = emit_ok && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			rem_q      <= '0;
			ovf_q      <= 1'b0;
			sort_cnt_q <= '0;
			ep_q       <= EP_END;
		end else begin
			state_q    <= state_d;
			sort_cnt_q <= sort_en ? sort_cnt_q + SW'(1) : '0;
			if (in_xfer) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (s_tlast) begin
					rem_q <= full ? cnt_q : cnt_q + CW'(1);
					ep_q  <= EP_END;
				end
			end
			if (emit_go) begin
				ep_q <= ep_d;
				if (pop) rem_q <= rem_q - CW'(1);
				if (fin) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// ---------------- request chain ----------------
	assign ctrl.pop     = emit_go && pop;
	assign ctrl.sort_en = sort_en;
	assign ctrl.parity  = sort_cnt_q[0];
	assign kcfg.cscan   = cscan;
	assign kcfg.head    = head_q;

	// the next free cell takes the request
	always_comb begin
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			load_en[i] = in_xfer && (cnt_q == CW'(i));
		end
	end

	for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
		logic [KEY_W-1:0] lk, rk;
		logic [POS_W-1:0] lv, rv;
		logic             lvl, rvl;

		if (g == 0) begin : g_first
			// nothing to the left: a zero key never wins a swap
			assign lk  = '0;
			assign lv  = '0;
			assign lvl = 1'b0;
		end else begin : g_mid_l
			assign lk  = key_c[g-1];
			assign lv  = val_c[g-1];
			assign lvl = vld_c[g-1];
		end

		if (g == MAX_REQUESTS - 1) begin : g_last
			// empty past the end: pops shift in an invalid entry
			assign rk  = '1;
			assign rv  = '0;
			assign rvl = 1'b0;
		end else begin : g_mid_r
			assign rk  = key_c[g+1];
			assign rv  = val_c[g+1];
			assign rvl = vld_c[g+1];
		end

		dhs_cell #(
			.CELL_ODD (1'(g % 2))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.kcfg      (kcfg),
			.load_en   (load_en[g]),
			.load_val  (s_tdata),
			.left_key  (lk),
			.left_val  (lv),
			.left_vld  (lvl),
			.right_key (rk),
			.right_val (rv),
			.right_vld (rvl),
			.key       (key_c[g]),
			.val       (val_c[g]),
			.vld       (vld_c[g])
		);
	end

	// ---------------- move generation ----------------
	assign front_up = val_c[0] > head_q;

	always_comb begin
		to_pos = val_c[0];
		pop    = 1'b0;
		fin    = 1'b0;
		ep_d   = ep_q;
		if (!sweep) begin
			pop = 1'b1;
			fin = (rem_q == CW'(1));
		end else begin
			unique case (ep_q)
				EP_END: begin
					if ((rem_q != '0) && front_up) begin
						pop = 1'b1;
					end else begin
						// sweep reaches the end cylinder
						to_pos = end_q;
						ep_d   = cscan ? EP_ZERO : EP_DONE;
						fin    = (rem_q == '0) && !cscan;
					end
				end
				EP_ZERO: begin
					// C-SCAN wrap back to cylinder zero
					to_pos = '0;
					ep_d   = EP_DONE;
					fin    = (rem_q == '0);
				end
				EP_DONE: begin
					pop = 1'b1;
					fin = (rem_q == CW'(1));
				end
				default: ep_d = EP_DONE;
			endcase
		end
	end

	assign move_dist = (to_pos >= prev_q) ? to_pos - prev_q : prev_q - to_pos;
	assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(move_dist);
	assign total_n   = (sum > {1'b0, SEEK_MAX}) ? SEEK_MAX : sum[TOTAL_W-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer && s_tlast) begin
			prev_q  <= head_q;
			total_q <= '0;
		end else if (emit_go) begin
			prev_q  <= to_pos;
			total_q <= total_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			from_q      <= prev_q;
			to_q        <= to_pos;
			dist_q      <= move_dist;
			out_total_q <= total_n;
			drop_q      <= ovf_q;
			fin_q       <= fin;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_total_q, dist_q, to_q, from_q};
	assign m_tuser  = drop_q;
	assign m_tlast  = fin_q;
endmodule
`default_nettype wire

// ----- src/dhs_checker.sv -----
// Port-level checks of the disk head scan scheduler, bound to the top level.
`default_nettype none
`include "disk_head_scan_scheduler_core_macros.svh"
module dhs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	// batch closed: no request is taken in the following cycle
	`DHS_ASSERT_NEXT(a_close_stops_input, s_tvalid && s_tready && s_tlast, !s_tready)

	// a move short of the last one keeps the request side closed
	`DHS_ASSERT_NOW(a_no_load_mid_schedule, m_tvalid && !m_tlast, !s_tready)

	// distance matches the endpoints
	`DHS_ASSERT_NOW(a_distance, m_tvalid,
		((m_tdata[31:16] >= m_tdata[15:0]) && (m_tdata[47:32] == m_tdata[31:16] - m_tdata[15:0]))
		|| ((m_tdata[31:16] < m_tdata[15:0]) && (m_tdata[47:32] == m_tdata[15:0] - m_tdata[31:16])))

	// running total already includes this move
	`DHS_ASSERT_NOW(a_total_covers_move, m_tvalid, m_tdata[71:48] >= {8'd0, m_tdata[47:32]})

	// stalled move holds
	`DHS_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
endmodule

bind disk_head_scan_scheduler_core dhs_checker u_dhs_checker (.*);
`default_nettype wire
